// File: hw/rtl/stcrw_pkg.sv
package stcrw_pkg;

	// Fixed field and datapath widths
	localparam int SAMPLE_W = 16;
	localparam int POS_W    = 32;
	localparam int IDX_W    = 16;
	localparam int LEN_W    = 13;
	localparam int OUT_W    = 40;
	localparam int FR_W     = 16;
	localparam int MUL_A_W  = 20;
	localparam int PROD_W   = MUL_A_W + FR_W + 1;
	localparam int P_W      = 36;
	localparam int ACC_W    = 54;

	// Request codes
	localparam logic [1:0] REQ_PLAIN = 2'd0;
	localparam logic [1:0] REQ_CUBIC = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_RES_ZERO,
		ST_RES_SAMPLE,
		ST_RD_B,
		ST_RD_C,
		ST_RD_D,
		ST_WAIT_D,
		ST_K1,
		ST_K2,
		ST_K3,
		ST_K4,
		ST_K5,
		ST_K6,
		ST_K7,
		ST_K8,
		ST_K9,
		ST_RES_CUBIC
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_WRITE,
		OP_RD_SINGLE,
		OP_RD_A,
		OP_RD_B,
		OP_RD_C,
		OP_RD_D,
		OP_K1,
		OP_K2,
		OP_K3,
		OP_K4,
		OP_K5,
		OP_K6,
		OP_K7,
		OP_K8,
		OP_K9,
		OP_RES_ZERO,
		OP_RES_SAMPLE,
		OP_RES_CUBIC
	} dp_op_t;

	typedef struct packed {
		logic   load;
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       len_zero;
		logic       len_lt4;
		logic       cubic_single;
		logic       clr_last;
	} status_t;

endpackage

// File: hw/rtl/stcrw_ram.sv
module stcrw_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic                           we,
	input  logic [AW-1:0]                  addr,
	input  logic [stcrw_pkg::SAMPLE_W-1:0] wdata,
	output logic [stcrw_pkg::SAMPLE_W-1:0] rdata
);

	logic [stcrw_pkg::SAMPLE_W-1:0] mem [DEPTH];

	// Single port: write or registered read
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: hw/rtl/stcrw_dp.sv
module stcrw_dp #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic        [stcrw_pkg::LEN_W-1:0]  cfg_wr_data,
	input  logic        [1:0]                   req_type,
	input  logic signed [stcrw_pkg::POS_W-1:0]  position,
	input  logic signed [stcrw_pkg::IDX_W-1:0]  write_index,
	input  logic signed [stcrw_pkg::SAMPLE_W-1:0] write_value,
	output logic signed [stcrw_pkg::OUT_W-1:0]  read_value,
	input  stcrw_pkg::cmd_t                     cmd,
	output stcrw_pkg::status_t                  status
);

	localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW      = (AW + 2 > 18) ? AW + 2 : 18;
	localparam int LEN_W   = stcrw_pkg::LEN_W;
	localparam int ACC_W   = stcrw_pkg::ACC_W;
	localparam int PROD_W  = stcrw_pkg::PROD_W;
	localparam int P_W     = stcrw_pkg::P_W;
	localparam int OUT_W   = stcrw_pkg::OUT_W;
	localparam int MUL_A_W = stcrw_pkg::MUL_A_W;
	localparam int FR_W_EXT = stcrw_pkg::FR_W;

	localparam logic        [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
	localparam logic        [CW-1:0] DEPTH_CW  = CW'(TABLE_DEPTH);
	localparam logic        [CW-1:0] FOUR_CW   = CW'(4);
	localparam logic signed [CW-1:0] ZERO_S    = '0;
	localparam logic signed [CW-1:0] ONE_S     = CW'(1);
	localparam logic signed [CW-1:0] TWO_S     = CW'(2);
	localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(32768);

	typedef enum logic [2:0] {
		TAG_NONE,
		TAG_A,
		TAG_B,
		TAG_C,
		TAG_D
	} rd_tag_t;

	// Registers
	logic        [LEN_W-1:0]  table_length_q;
	logic        [AW-1:0]     clr_q;
	rd_tag_t                  tag_q, tag_d;
	logic        [1:0]        type_q;
	logic signed [31:0]       pos_q;
	logic signed [15:0]       widx_q;
	logic signed [15:0]       wval_q;
	logic signed [15:0]       a_q, b_q, c_q, d_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [P_W-1:0]    p_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [OUT_W-1:0]  read_value_q;

	// Decode signals
	logic        [CW-1:0] len_cw;
	logic signed [CW-1:0] len_s, n_cw, widx_cw;
	logic signed [CW-1:0] plain_idx, single_idx, write_idx;
	logic signed [CW-1:0] n_m1, n_p1, n_p2;
	logic                 cubic_low, cubic_high;

	// Memory port
	logic                 ram_en, ram_we;
	logic        [AW-1:0] ram_addr;
	logic        [15:0]   ram_wdata;
	logic        [15:0]   ram_rdata;

	// Arithmetic
	logic signed [16:0]          cmb;
	logic signed [17:0]          lin;
	logic signed [MUL_A_W-1:0]   coef, mul_a;
	logic signed [FR_W_EXT:0]    fr_s;
	logic signed [PROD_W-1:0]    mul_p;
	logic signed [ACC_W-1:0]     prod_ext, prod_sh;

	assign len_cw = ({{(CW - LEN_W){1'b0}}, table_length_q} > DEPTH_CW) ? DEPTH_CW
		: {{(CW - LEN_W){1'b0}}, table_length_q};
	assign len_s   = $signed(len_cw);
	assign n_cw    = {{(CW - 16){pos_q[31]}}, pos_q[31:16]};
	assign widx_cw = {{(CW - 16){widx_q[15]}}, widx_q};

	assign cubic_low  = (n_cw < ONE_S) || (pos_q == 32'sh0001_0000);
	assign cubic_high = (n_cw >= (len_s - TWO_S));

	always_comb begin
		if (n_cw < ZERO_S) begin
			plain_idx = ZERO_S;
		end else if (n_cw >= len_s) begin
			plain_idx = len_s - ONE_S;
		end else begin
			plain_idx = n_cw;
		end

		if (widx_cw < ZERO_S) begin
			write_idx = ZERO_S;
		end else if (widx_cw >= len_s) begin
			write_idx = len_s - ONE_S;
		end else begin
			write_idx = widx_cw;
		end

		if (type_q == stcrw_pkg::REQ_CUBIC) begin
			single_idx = cubic_low ? ONE_S : (len_s - TWO_S);
		end else begin
			single_idx = plain_idx;
		end
	end

	assign n_m1 = n_cw - ONE_S;
	assign n_p1 = n_cw + ONE_S;
	assign n_p2 = n_cw + TWO_S;

	assign status.req_type     = type_q;
	assign status.len_zero     = (len_cw == '0);
	assign status.len_lt4      = (len_cw < FOUR_CW);
	assign status.cubic_single = cubic_low || cubic_high;
	assign status.clr_last     = (clr_q == LAST_ADDR);

	// Memory address and tag selection
	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = clr_q;
		ram_wdata = '0;
		tag_d     = TAG_NONE;
		case (cmd.op)
			stcrw_pkg::OP_CLEAR: begin
				ram_en = 1'b1;
				ram_we = 1'b1;
			end
			stcrw_pkg::OP_WRITE: begin
				ram_en    = 1'b1;
				ram_we    = 1'b1;
				ram_addr  = write_idx[AW-1:0];
				ram_wdata = wval_q;
			end
			stcrw_pkg::OP_RD_SINGLE: begin
				ram_en   = 1'b1;
				ram_addr = single_idx[AW-1:0];
			end
			stcrw_pkg::OP_RD_A: begin
				ram_en   = 1'b1;
				ram_addr = n_m1[AW-1:0];
				tag_d    = TAG_A;
			end
			stcrw_pkg::OP_RD_B: begin
				ram_en   = 1'b1;
				ram_addr = n_cw[AW-1:0];
				tag_d    = TAG_B;
			end
			stcrw_pkg::OP_RD_C: begin
				ram_en   = 1'b1;
				ram_addr = n_p1[AW-1:0];
				tag_d    = TAG_C;
			end
			stcrw_pkg::OP_RD_D: begin
				ram_en   = 1'b1;
				ram_addr = n_p2[AW-1:0];
				tag_d    = TAG_D;
			end
			default: begin
			end
		endcase
	end

	stcrw_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Cubic coefficients from the four neighbors
	assign cmb  = {c_q[15], c_q} - {b_q[15], b_q};
	assign lin  = {b_q[15], b_q, 1'b0} - {{2{a_q[15]}}, a_q} - {{2{c_q[15]}}, c_q};
	assign coef = {{4{a_q[15]}}, a_q} - {{4{d_q[15]}}, d_q}
		+ {{2{cmb[16]}}, cmb, 1'b0} + {{3{cmb[16]}}, cmb};

	always_comb begin
		case (cmd.op)
			stcrw_pkg::OP_K1: mul_a = coef;
			stcrw_pkg::OP_K3,
			stcrw_pkg::OP_K7: mul_a = {2'b00, p_q[17:0]};
			default:          mul_a = {{2{p_q[P_W-1]}}, p_q[P_W-1:18]};
		endcase
	end

	assign fr_s     = {1'b0, pos_q[15:0]};
	assign mul_p    = mul_a * fr_s;
	assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
	assign prod_sh  = {prod_ext[ACC_W-19:0], 18'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_length_q <= '0;
			clr_q          <= '0;
			tag_q          <= TAG_NONE;
		end else begin
			if (cfg_wr_en) begin
				table_length_q <= cfg_wr_data;
			end
			if (cmd.op == stcrw_pkg::OP_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			tag_q <= tag_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req_type;
			pos_q  <= position;
			widx_q <= write_index;
			wval_q <= write_value;
		end

		// Latch the sample that the previous read fetched
		case (tag_q)
			TAG_A:   a_q <= ram_rdata;
			TAG_B:   b_q <= ram_rdata;
			TAG_C:   c_q <= ram_rdata;
			TAG_D:   d_q <= ram_rdata;
			default: begin
			end
		endcase

		case (cmd.op)
			stcrw_pkg::OP_K1: begin
				prod_q <= mul_p;
			end
			stcrw_pkg::OP_K2: begin
				p_q <= prod_q[P_W-1:0] + {{2{lin[17]}}, lin, 16'b0};
			end
			stcrw_pkg::OP_K3: begin
				prod_q <= mul_p;
				acc_q  <= {{(ACC_W - 50){cmb[16]}}, cmb, 33'b0}
					+ {{(ACC_W - P_W - 16){p_q[P_W-1]}}, p_q, 16'b0};
			end
			stcrw_pkg::OP_K4: begin
				prod_q <= mul_p;
				acc_q  <= acc_q - prod_ext;
			end
			stcrw_pkg::OP_K5: begin
				acc_q <= acc_q - prod_sh;
			end
			stcrw_pkg::OP_K6: begin
				p_q <= acc_q[P_W+16:17];
			end
			stcrw_pkg::OP_K7: begin
				prod_q <= mul_p;
				acc_q  <= {{(ACC_W - 48){b_q[15]}}, b_q, 32'b0} + HALF_LSB;
			end
			stcrw_pkg::OP_K8: begin
				prod_q <= mul_p;
				acc_q  <= acc_q + prod_ext;
			end
			stcrw_pkg::OP_K9: begin
				acc_q <= acc_q + prod_sh;
			end
			stcrw_pkg::OP_RES_ZERO: begin
				read_value_q <= '0;
			end
			stcrw_pkg::OP_RES_SAMPLE: begin
				read_value_q <= {{(OUT_W - 32){ram_rdata[15]}}, ram_rdata, 16'b0};
			end
			stcrw_pkg::OP_RES_CUBIC: begin
				// Result magnitude stays below 2^37, so it is passed on without a clamp
				read_value_q <= {{(OUT_W - ACC_W + 16){acc_q[ACC_W-1]}}, acc_q[ACC_W-1:16]};
			end
			default: begin
			end
		endcase
	end

	assign read_value = read_value_q;

endmodule

// File: hw/rtl/stcrw_ctrl.sv
module stcrw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  stcrw_pkg::status_t status,
	output stcrw_pkg::cmd_t    cmd
);

	stcrw_pkg::state_t state_q, state_d;
	logic              out_valid_q, out_valid_d;
	logic              out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stcrw_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && !out_ready;
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.op      = stcrw_pkg::OP_NONE;
		case (state_q)
			stcrw_pkg::ST_CLEAR: begin
				cmd.op = stcrw_pkg::OP_CLEAR;
				if (status.clr_last) begin
					state_d = stcrw_pkg::ST_IDLE;
				end
			end
			stcrw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stcrw_pkg::ST_DECODE;
				end
			end
			stcrw_pkg::ST_DECODE: begin
				state_d = stcrw_pkg::ST_IDLE;
				case (status.req_type)
					stcrw_pkg::REQ_PLAIN: begin
						if (status.len_zero) begin
							state_d = stcrw_pkg::ST_RES_ZERO;
						end else begin
							cmd.op  = stcrw_pkg::OP_RD_SINGLE;
							state_d = stcrw_pkg::ST_RES_SAMPLE;
						end
					end
					stcrw_pkg::REQ_CUBIC: begin
						if (status.len_lt4) begin
							state_d = stcrw_pkg::ST_RES_ZERO;
						end else if (status.cubic_single) begin
							cmd.op  = stcrw_pkg::OP_RD_SINGLE;
							state_d = stcrw_pkg::ST_RES_SAMPLE;
						end else begin
							cmd.op  = stcrw_pkg::OP_RD_A;
							state_d = stcrw_pkg::ST_RD_B;
						end
					end
					stcrw_pkg::REQ_WRITE: begin
						if (!status.len_zero) begin
							cmd.op = stcrw_pkg::OP_WRITE;
						end
					end
					default: begin
					end
				endcase
			end
			stcrw_pkg::ST_RES_ZERO: begin
				if (out_free) begin
					cmd.op      = stcrw_pkg::OP_RES_ZERO;
					out_valid_d = 1'b1;
					state_d     = stcrw_pkg::ST_IDLE;
				end
			end
			stcrw_pkg::ST_RES_SAMPLE: begin
				if (out_free) begin
					cmd.op      = stcrw_pkg::OP_RES_SAMPLE;
					out_valid_d = 1'b1;
					state_d     = stcrw_pkg::ST_IDLE;
				end
			end
			stcrw_pkg::ST_RD_B: begin
				cmd.op  = stcrw_pkg::OP_RD_B;
				state_d = stcrw_pkg::ST_RD_C;
			end
			stcrw_pkg::ST_RD_C: begin
				cmd.op  = stcrw_pkg::OP_RD_C;
				state_d = stcrw_pkg::ST_RD_D;
			end
			stcrw_pkg::ST_RD_D: begin
				cmd.op  = stcrw_pkg::OP_RD_D;
				state_d = stcrw_pkg::ST_WAIT_D;
			end
			stcrw_pkg::ST_WAIT_D: begin
				state_d = stcrw_pkg::ST_K1;
			end
			stcrw_pkg::ST_K1: begin
				cmd.op  = stcrw_pkg::OP_K1;
				state_d = stcrw_pkg::ST_K2;
			end
			stcrw_pkg::ST_K2: begin
				cmd.op  = stcrw_pkg::OP_K2;
				state_d = stcrw_pkg::ST_K3;
			end
			stcrw_pkg::ST_K3: begin
				cmd.op  = stcrw_pkg::OP_K3;
				state_d = stcrw_pkg::ST_K4;
			end
			stcrw_pkg::ST_K4: begin
				cmd.op  = stcrw_pkg::OP_K4;
				state_d = stcrw_pkg::ST_K5;
			end
			stcrw_pkg::ST_K5: begin
				cmd.op  = stcrw_pkg::OP_K5;
				state_d = stcrw_pkg::ST_K6;
			end
			stcrw_pkg::ST_K6: begin
				cmd.op  = stcrw_pkg::OP_K6;
				state_d = stcrw_pkg::ST_K7;
			end
			stcrw_pkg::ST_K7: begin
				cmd.op  = stcrw_pkg::OP_K7;
				state_d = stcrw_pkg::ST_K8;
			end
			stcrw_pkg::ST_K8: begin
				cmd.op  = stcrw_pkg::OP_K8;
				state_d = stcrw_pkg::ST_K9;
			end
			stcrw_pkg::ST_K9: begin
				cmd.op  = stcrw_pkg::OP_K9;
				state_d = stcrw_pkg::ST_RES_CUBIC;
			end
			stcrw_pkg::ST_RES_CUBIC: begin
				if (out_free) begin
					cmd.op      = stcrw_pkg::OP_RES_CUBIC;
					out_valid_d = 1'b1;
					state_d     = stcrw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = stcrw_pkg::ST_IDLE;
			end
		endcase
	end

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == stcrw_pkg::ST_DECODE)
		else $error("accepted item did not go to decode");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == stcrw_pkg::ST_RES_ZERO
			|| $past(state_q) == stcrw_pkg::ST_RES_SAMPLE
			|| $past(state_q) == stcrw_pkg::ST_RES_CUBIC)
		else $error("result raised outside a result state");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == stcrw_pkg::ST_IDLE && $past(state_q) == stcrw_pkg::ST_CLEAR
			|-> $past(status.clr_last))
		else $error("clearing pass ended early");

	a_cubic_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == stcrw_pkg::ST_RES_CUBIC && out_valid_q && !out_ready
			|=> state_q == stcrw_pkg::ST_RES_CUBIC)
		else $error("cubic result overwrote a waiting result");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == stcrw_pkg::ST_CLEAR |-> !out_valid_q)
		else $error("result present during clearing pass");

endmodule

// File: hw/rtl/sample_table_cubic_read_write_core.sv
// Channel   Direction  Handshake               Payload
// cfg       in         cfg_wr_en               cfg_wr_data (table_length, 13 bits)
// in        in         in_valid / in_ready     req_type, position, write_index, write_value
// out       out        out_valid / out_ready   read_value (40 bits, signed Q.16)
//
// Reset starts a clearing pass that zeroes every table entry; no item
// is taken until it ends, while configuration writes are taken throughout.
// One item is in work at a time, sequenced over the single table memory port:
// a write is made from decode, a plain or edge-case read makes one table read, and an
// interior cubic read makes 4 table reads, then 9 steps of one shared 20x17 multiplier.
// A finished result waits in the output register while the next item is accepted;
// a further result holds in its result state until out_ready frees the register.
module sample_table_cubic_read_write_core #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_wr_en,
	input  logic        [stcrw_pkg::LEN_W-1:0]    cfg_wr_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic        [1:0]                     req_type,
	input  logic signed [stcrw_pkg::POS_W-1:0]    position,
	input  logic signed [stcrw_pkg::IDX_W-1:0]    write_index,
	input  logic signed [stcrw_pkg::SAMPLE_W-1:0] write_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [stcrw_pkg::OUT_W-1:0]    read_value
);

	// Command from the sequencer, status back from the datapath
	stcrw_pkg::cmd_t    cmd;
	stcrw_pkg::status_t status;

	// Controller: clearing pass, request decode, read and arithmetic sequencing,
	// and the valid bit of the output register
	stcrw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: length register, item capture, index clamping, table memory,
	// shared multiplier with accumulator, and the output data register
	stcrw_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_type    (req_type),
		.position    (position),
		.write_index (write_index),
		.write_value (write_value),
		.read_value  (read_value),
		.cmd         (cmd),
		.status      (status)
	);

endmodule
